### design/wrr_classifier_with_congestion_defines.svh
// assertion macros for the weighted round-robin steering block
// expects i_clk and i_rst_n in the scope of each use
`ifndef WRR_CLASSIFIER_WITH_CONGESTION_DEFINES_SVH
`define WRR_CLASSIFIER_WITH_CONGESTION_DEFINES_SVH

// property must hold at every edge outside reset
`define WRR_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define WRR_NEVER(lbl, cond, msg) \
    `WRR_CHECK(lbl, !(cond), msg)

`endif

### design/wrr_pkg.sv
// shared types and constants for the weighted round-robin steering block
// no dependencies
package wrr_pkg;

    localparam int MAX_QUEUES       = 8;
    localparam int QIDX_W           = 3;
    localparam int TGT_W            = 4;
    localparam int MASK_W           = 8;
    localparam int CFG_W            = 64;
    localparam int CFG_IDX_W        = 1;
    localparam int ORDER_W          = 24;
    localparam int WEIGHT_FIELD_W   = 8;
    localparam int DEF_NUM_QUEUES   = 8;
    localparam int DEF_WEIGHT_BITS  = 8;

    localparam logic [CFG_W-1:0]   WEIGHT_RESET = 64'h0101_0101_0101_0101;
    localparam logic [ORDER_W-1:0] ORDER_RESET  = 24'hFAC688;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 1'b1;

    typedef enum logic {
        ACT_CLASSIFY = 1'b0,
        ACT_SETCONG  = 1'b1
    } t_action;

    // per-queue status seen by the scan chain
    typedef struct packed {
        logic open;
        logic has_credit;
        logic can_refill;
    } t_qstat;

    // per-queue update command
    typedef struct packed {
        logic refill;
        logic take;
        logic cong_we;
        logic cong_val;
    } t_qcmd;

    // token handed from slot to slot
    typedef struct packed {
        logic              any_open;
        logic              found1;
        logic [QIDX_W-1:0] sel1;
        logic              found2;
        logic [QIDX_W-1:0] sel2;
    } t_scan;

endpackage

### design/wrr_classifier_with_congestion.sv
// weighted round-robin steering: an accepted item is held in the item register, and a classify
// item moves on to the result register once that is free; no new item is taken while the item register is busy
// a set-congestion item gives no result
// synchronous active-low reset clears credits, congestion flags and handshake state
// and loads the default weights (all one) and the identity visit order
`include "wrr_classifier_with_congestion_defines.svh"
module wrr_classifier_with_congestion #(
    parameter int NUM_QUEUES  = wrr_pkg::DEF_NUM_QUEUES,
    parameter int WEIGHT_BITS = wrr_pkg::DEF_WEIGHT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [wrr_pkg::MASK_W-1:0]        i_ready_mask,
    input  logic [wrr_pkg::QIDX_W-1:0]        i_queue_index,
    input  logic                              i_congested_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wrr_pkg::TGT_W-1:0]         o_target_queue,
    output logic                              o_dropped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wrr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wrr_pkg::CFG_W-1:0]         i_cfg_data
);
    import wrr_pkg::*;

    logic [CFG_W-1:0]   r_weights;
    logic [ORDER_W-1:0] r_order;

    logic               r_busy;
    logic               n_busy;
    t_action            r_action;
    logic [MASK_W-1:0]  r_ready;
    logic [QIDX_W-1:0]  r_qidx;
    logic               r_cval;

    logic               r_ov;
    logic               n_ov;
    logic [TGT_W-1:0]   r_target;
    logic [TGT_W-1:0]   n_target;
    logic               r_dropped;
    logic               n_dropped;

    logic               accept;
    logic               out_free;
    logic               do_set;
    logic               do_cls;
    logic               need_refill;
    logic               take_any;
    logic [QIDX_W-1:0]  take_q;

    logic [MAX_QUEUES-1:0]          in_order;
    t_qstat [MAX_QUEUES-1:0]        qstat;
    t_qcmd  [MAX_QUEUES-1:0]        qcmd;
    t_scan  [NUM_QUEUES:0]          chain;
    t_scan                          scan;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= WEIGHT_RESET;
            r_order   <= ORDER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WEIGHTS: r_weights <= i_cfg_data;
                REG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                default:     r_weights <= r_weights;
            endcase
        end
    end

    // item register
    assign o_in_stall = r_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        out_free = !r_ov || !i_out_stall;
        do_set   = r_busy && (r_action == ACT_SETCONG);
        do_cls   = r_busy && (r_action == ACT_CLASSIFY) && out_free;
        if (accept) begin
            n_busy = 1'b1;
        end else if (do_set || do_cls) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_ready  <= i_ready_mask;
            r_qidx   <= i_queue_index;
            r_cval   <= i_congested_value;
        end
    end

    // queues named by some slot of the visit order
    always_comb begin
        in_order = '0;
        for (int q = 0; q < MAX_QUEUES; q++) begin
            for (int s = 0; s < NUM_QUEUES; s++) begin
                if (r_order[QIDX_W*s +: QIDX_W] == QIDX_W'(q)) begin
                    in_order[q] = 1'b1;
                end
            end
        end
    end

    // queue cells
    for (genvar gq = 0; gq < MAX_QUEUES; gq++) begin : g_queue
        if (gq < NUM_QUEUES) begin : g_cell
            wrr_qcell #(
                .WEIGHT_BITS (WEIGHT_BITS)
            ) u_qcell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_weight   (r_weights[WEIGHT_FIELD_W*gq +: WEIGHT_BITS]),
                .i_in_order (in_order[gq]),
                .i_ready    (r_ready[gq]),
                .i_cmd      (qcmd[gq]),
                .o_stat     (qstat[gq])
            );
        end else begin : g_none
            assign qstat[gq] = '0;
        end
    end

    // slot scan chain
    assign chain[0] = '0;

    for (genvar gs = 0; gs < NUM_QUEUES; gs++) begin : g_slot
        wrr_slot #(
            .NUM_QUEUES (NUM_QUEUES)
        ) u_slot (
            .i_queue (r_order[QIDX_W*gs +: QIDX_W]),
            .i_stat  (qstat),
            .i_scan  (chain[gs]),
            .o_scan  (chain[gs+1])
        );
    end

    assign scan = chain[NUM_QUEUES];

    // decision
    always_comb begin
        need_refill = scan.any_open && !scan.found1;
        take_any    = 1'b0;
        take_q      = scan.sel1;
        n_target    = TGT_W'(NUM_QUEUES);
        n_dropped   = 1'b1;
        if (scan.found1) begin
            take_any  = 1'b1;
            take_q    = scan.sel1;
        end else if (need_refill && scan.found2) begin
            take_any  = 1'b1;
            take_q    = scan.sel2;
        end
        if (take_any) begin
            n_target  = {1'b0, take_q};
            n_dropped = 1'b0;
        end
    end

    always_comb begin
        for (int q = 0; q < MAX_QUEUES; q++) begin
            qcmd[q].refill   = do_cls && need_refill;
            qcmd[q].take     = do_cls && take_any && (take_q == QIDX_W'(q));
            qcmd[q].cong_we  = do_set && (r_qidx == QIDX_W'(q));
            qcmd[q].cong_val = r_cval;
        end
    end

    // result register
    always_comb begin
        if (do_cls) begin
            n_ov = 1'b1;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_cls) begin
            r_target  <= n_target;
            r_dropped <= n_dropped;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_target_queue = r_target;
    assign o_dropped      = r_dropped;

    `WRR_CHECK(a_drop_matches_bin, r_ov |-> (r_dropped == (r_target == TGT_W'(NUM_QUEUES))), "dropped flag disagrees with target")
    `WRR_CHECK(a_cls_lands, do_cls |=> (r_ov && !r_busy), "classify item did not reach the result register")
    `WRR_CHECK(a_pick_is_ready, (do_cls && !n_dropped) |-> r_ready[n_target[QIDX_W-1:0]], "chosen queue was not ready")
    `WRR_NEVER(a_set_no_result, do_set && !do_cls && !r_ov && $past(!r_ov) && n_ov, "set-congestion item produced a result")

endmodule

### design/wrr_qcell.sv
// queue cell: credit counter and congestion flag of one output queue
// depends on wrr_pkg
module wrr_qcell #(
    parameter int WEIGHT_BITS = wrr_pkg::DEF_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_in_order,
    input  logic                   i_ready,
    input  wrr_pkg::t_qcmd         i_cmd,
    output wrr_pkg::t_qstat        o_stat
);
    import wrr_pkg::*;

    logic [WEIGHT_BITS-1:0] r_credit;
    logic [WEIGHT_BITS-1:0] n_credit;
    logic                   r_cong;
    logic                   n_cong;

    always_comb begin
        n_credit = r_credit;
        if (i_cmd.refill && !r_cong && i_in_order) begin
            n_credit = i_cmd.take ? (i_weight - WEIGHT_BITS'(1)) : i_weight;
        end else if (i_cmd.take) begin
            n_credit = r_credit - WEIGHT_BITS'(1);
        end
        n_cong = i_cmd.cong_we ? i_cmd.cong_val : r_cong;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_cong   <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r_cong   <= n_cong;
        end
    end

    always_comb begin
        o_stat.open       = i_ready && !r_cong && i_in_order;
        o_stat.has_credit = (r_credit != '0);
        o_stat.can_refill = (i_weight != '0);
    end

endmodule

### design/wrr_slot.sv
// slot cell: one visit slot of the priority scan, passes the scan token on
// depends on wrr_pkg
module wrr_slot #(
    parameter int NUM_QUEUES = wrr_pkg::DEF_NUM_QUEUES
) (
    input  logic [wrr_pkg::QIDX_W-1:0]                   i_queue,
    input  wrr_pkg::t_qstat [wrr_pkg::MAX_QUEUES-1:0]    i_stat,
    input  wrr_pkg::t_scan                               i_scan,
    output wrr_pkg::t_scan                               o_scan
);
    import wrr_pkg::*;

    logic   in_range;
    t_qstat st;
    logic   hit1;
    logic   hit2;

    always_comb begin
        in_range = ({1'b0, i_queue} < (QIDX_W + 1)'(NUM_QUEUES));
        st       = i_stat[i_queue];
        hit1     = in_range && st.open && st.has_credit && !i_scan.found1;
        hit2     = in_range && st.open && st.can_refill && !i_scan.found2;

        o_scan          = i_scan;
        o_scan.any_open = i_scan.any_open || (in_range && st.open);
        if (hit1) begin
            o_scan.found1 = 1'b1;
            o_scan.sel1   = i_queue;
        end
        if (hit2) begin
            o_scan.found2 = 1'b1;
            o_scan.sel2   = i_queue;
        end
    end

endmodule
